>>> hw/rtl/ffba_pkg.sv
// Shared types and codes for the first-fit block allocator.
package ffba_pkg;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_BADSIZE = 2'd1,
        ST_NOFIT   = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam int unsigned ARENA_BYTES = 4096;
    localparam int unsigned ARENA_BASE  = 4;
    localparam int unsigned SIZE_GRAIN  = 8;

endpackage

>>> hw/rtl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator with free-chunk coalescing.
//
// channel | dir | tuser     | tdata fields (low bit first)
// s_axis  | in  | action[0] | request_bytes[11:0], block_address[23:12]
// m_axis  | out | -         | status[1:0], granted_address[13:2], blocks_in_use[21:14],
//         |     |           | free_bytes[33:22], used_bytes[45:34], smallest_free[57:46],
//         |     |           | largest_free[69:58], pad to 72
//
// The search, table shift and statistics walk each visit the table memory one
// entry at a time through its single read port.
// After reset a pass over all MAP_DEPTH map entries clears the map valid bits and
// seeds chunk zero; s_axis_tready stays low during the pass.
// s_axis_tready is high only in idle; the result waits in the output register.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_FREE_ENTRIES = 256,
    parameter int HEADER_BYTES     = 8,
    parameter int MIN_SPLIT_BYTES  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // request_bytes, block_address
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // status, granted, in_use, free, used, small, large
);
    localparam int MAP_DEPTH = ARENA_BYTES / SIZE_GRAIN;
    localparam int AW  = $clog2(MAX_FREE_ENTRIES);
    localparam int CW  = AW + 1;
    localparam int MW  = $clog2(MAP_DEPTH);
    localparam int DW  = $clog2(ARENA_BYTES) + 1;
    localparam logic [DW-1:0] USABLE = DW'(ARENA_BYTES - ARENA_BASE);
    localparam logic [DW-1:0] HDR    = DW'(HEADER_BYTES);
    localparam logic [DW-1:0] SPLIT  = DW'(MIN_SPLIT_BYTES);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_ACHK, S_ARD, S_AEVAL, S_SHRD, S_SHWR,
        S_FRD, S_FEVAL, S_FMAP, S_FACT, S_INSRD, S_INSWR,
        S_STRD, S_STACC, S_OUT
    } state_t;

    logic [DW-1:0] start_mem [MAX_FREE_ENTRIES];
    logic [DW-1:0] len_mem   [MAX_FREE_ENTRIES];
    logic [12:0]   blen_mem  [MAP_DEPTH];

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next, idx_reg, idx_next;
    logic [MW-1:0] clr_reg, clr_next;
    logic [7:0]    blocks_reg, blocks_next;
    logic          act_reg, act_next;
    logic [11:0]   req_reg, req_next, addr_reg, addr_next;
    logic [DW-1:0] need_reg, need_next, hdr_reg, hdr_next;
    logic [DW-1:0] ps_reg, ps_next, pl_reg, pl_next;
    logic [DW-1:0] sum_reg, sum_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [DW-1:0] blen_reg, blen_next;
    logic [1:0]    status_reg, status_next;
    logic [11:0]   grant_reg, grant_next;
    logic [71:0]   tdata_reg, tdata_next;
    logic          tvalid_reg, tvalid_next;
    logic [1:0]    mode_reg, mode_next;

    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_start, rd_len;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_start, wr_len;
    logic          bl_we;
    logic [MW-1:0] bl_idx, mi;
    logic [12:0]   bl_wd;
    logic [12:0]   bl_rd;

    logic [DW-1:0] hdrx, s_len;
    logic          fit, left, right;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_mem[wr_addr] <= wr_start;
            len_mem[wr_addr]   <= wr_len;
        end
        rd_start <= start_mem[rd_addr];
        rd_len   <= len_mem[rd_addr];
        if (bl_we)
            blen_mem[bl_idx] <= bl_wd;
        bl_rd <= blen_mem[bl_idx];
    end

    assign hdrx = DW'(addr_reg) - HDR;
    assign mi   = MW'((hdrx - DW'(ARENA_BASE)) >> 3);
    assign fit  = (rd_len == need_reg) || (rd_len >= need_reg + SPLIT);
    assign s_len = (rd_len >= SPLIT) ? rd_len - SPLIT : '0;
    assign left  = (ps_reg + pl_reg == hdr_reg) && (idx_reg != '0);
    assign right = (idx_reg < cnt_reg) && (hdr_reg + blen_reg == rd_start);

    always_comb
    begin
        state_next = state_reg; cnt_next = cnt_reg; idx_next = idx_reg;
        blocks_next = blocks_reg; act_next = act_reg; req_next = req_reg;
        addr_next = addr_reg; need_next = need_reg; hdr_next = hdr_reg;
        ps_next = ps_reg; pl_next = pl_reg; sum_next = sum_reg;
        lo_next = lo_reg; hi_next = hi_reg; blen_next = blen_reg;
        status_next = status_reg; grant_next = grant_reg;
        tdata_next = tdata_reg; tvalid_next = tvalid_reg; mode_next = mode_reg;
        clr_next = clr_reg;
        rd_addr = AW'(idx_reg); wr_en = 1'b0; wr_addr = AW'(idx_reg);
        wr_start = rd_start; wr_len = rd_len; bl_we = 1'b0; bl_idx = mi;
        bl_wd = {1'b1, req_reg};
        if (tvalid_reg && m_axis_tready)
            tvalid_next = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                bl_we = 1'b1; bl_idx = clr_reg; bl_wd = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '0)
                begin
                    wr_en = 1'b1; wr_addr = '0;
                    wr_start = DW'(ARENA_BASE); wr_len = USABLE;
                end
                if (clr_reg == MW'(MAP_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    act_next = s_axis_tuser;
                    req_next = s_axis_tdata[11:0];
                    addr_next = s_axis_tdata[23:12];
                    grant_next = '0;
                    idx_next = '0;
                    state_next = S_ACHK;
                end
            end
            S_ACHK:
            begin
                need_next = DW'(req_reg) + HDR;
                hdr_next = hdrx;
                if (act_reg == ACT_ALLOC)
                begin
                    if (req_reg == '0 || req_reg[2:0] != 3'd0)
                    begin
                        status_next = ST_BADSIZE; state_next = S_STRD;
                    end
                    else
                        state_next = S_ARD;
                end
                else if (addr_reg == '0 || DW'(addr_reg) < DW'(ARENA_BASE) + HDR
                         || hdrx[2:0] != 3'(ARENA_BASE)
                         || ((hdrx - DW'(ARENA_BASE)) >> 3) >= DW'(MAP_DEPTH))
                begin
                    status_next = ST_IGNORED; state_next = S_STRD;
                end
                else
                    state_next = S_FMAP;
            end
            S_ARD:
            begin
                if (idx_reg >= cnt_reg)
                begin
                    status_next = ST_NOFIT; state_next = S_STRD;
                end
                else
                    state_next = S_AEVAL;
            end
            S_AEVAL:
            begin
                if (!fit)
                begin
                    idx_next = idx_reg + 1'b1; state_next = S_ARD;
                end
                else
                begin
                    status_next = ST_DONE;
                    grant_next = 12'(rd_start + HDR);
                    hdr_next = rd_start;
                    bl_idx = MW'((rd_start - DW'(ARENA_BASE)) >> 3);
                    bl_we = 1'b1;
                    blocks_next = blocks_reg + 8'd1;
                    if (rd_len == need_reg)
                    begin
                        cnt_next = cnt_reg - 1'b1; state_next = S_SHRD;
                        idx_next = idx_reg + 1'b1;
                    end
                    else
                    begin
                        wr_en = 1'b1; wr_start = rd_start + need_reg;
                        wr_len = rd_len - need_reg; state_next = S_STRD;
                    end
                end
            end
            S_SHRD:
            begin
                if (idx_reg > cnt_reg)
                    state_next = S_STRD;
                else
                    state_next = S_SHWR;
            end
            S_SHWR:
            begin
                wr_en = 1'b1; wr_addr = AW'(idx_reg - 1'b1);
                idx_next = idx_reg + 1'b1; state_next = S_SHRD;
            end
            S_FMAP:
            begin
                if (!bl_rd[12])
                begin
                    status_next = ST_IGNORED; state_next = S_STRD;
                end
                else
                begin
                    blen_next = DW'(bl_rd[11:0]) + HDR;
                    idx_next = '0; ps_next = '0; pl_next = '0;
                    state_next = S_FRD;
                end
            end
            S_FRD:
                state_next = S_FEVAL;
            S_FEVAL:
            begin
                if (idx_reg < cnt_reg && rd_start <= hdr_reg)
                begin
                    ps_next = rd_start; pl_next = rd_len;
                    idx_next = idx_reg + 1'b1; state_next = S_FRD;
                end
                else
                    state_next = S_FACT;
            end
            S_FACT:
            begin
                status_next = ST_DONE;
                if (left || right || cnt_reg < CW'(MAX_FREE_ENTRIES))
                begin
                    bl_we = 1'b1; bl_wd = '0;
                    blocks_next = blocks_reg - 8'd1;
                end
                if (left && right)
                begin
                    wr_en = 1'b1; wr_addr = AW'(idx_reg - 1'b1);
                    wr_start = ps_reg; wr_len = pl_reg + blen_reg + rd_len;
                    cnt_next = cnt_reg - 1'b1; idx_next = idx_reg + 1'b1;
                    state_next = S_SHRD;
                end
                else if (left)
                begin
                    wr_en = 1'b1; wr_addr = AW'(idx_reg - 1'b1);
                    wr_start = ps_reg; wr_len = pl_reg + blen_reg;
                    state_next = S_STRD;
                end
                else if (right)
                begin
                    wr_en = 1'b1; wr_start = hdr_reg; wr_len = rd_len + blen_reg;
                    state_next = S_STRD;
                end
                else if (cnt_reg >= CW'(MAX_FREE_ENTRIES))
                begin
                    status_next = ST_IGNORED; state_next = S_STRD;
                end
                else
                begin
                    ps_next = DW'(idx_reg);
                    idx_next = cnt_reg; cnt_next = cnt_reg + 1'b1;
                    state_next = S_INSRD;
                end
            end
            S_INSRD:
            begin
                rd_addr = AW'(idx_reg - 1'b1);
                if (CW'(ps_reg) == idx_reg)
                begin
                    wr_en = 1'b1; wr_start = hdr_reg; wr_len = blen_reg;
                    state_next = S_STRD;
                end
                else
                    state_next = S_INSWR;
            end
            S_INSWR:
            begin
                wr_en = 1'b1;
                idx_next = idx_reg - 1'b1; state_next = S_INSRD;
            end
            S_STRD:
            begin
                if (mode_reg == 2'd0)
                begin
                    idx_next = '0; sum_next = '0; lo_next = '0; hi_next = '0;
                    mode_next = 2'd1;
                end
                else if (idx_reg >= cnt_reg)
                begin
                    mode_next = 2'd0; state_next = S_OUT;
                end
                else
                    state_next = S_STACC;
            end
            S_STACC:
            begin
                sum_next = sum_reg + s_len;
                if (idx_reg == '0 || s_len < lo_reg) lo_next = s_len;
                if (idx_reg == '0 || s_len > hi_reg) hi_next = s_len;
                idx_next = idx_reg + 1'b1; state_next = S_STRD;
            end
            S_OUT:
            begin
                if (!tvalid_reg || m_axis_tready)
                begin
                    tvalid_next = 1'b1;
                    tdata_next = {2'b00, 12'(hi_reg), 12'(lo_reg),
                        12'((USABLE >= sum_reg) ? USABLE - sum_reg : '0),
                        12'(sum_reg), blocks_reg, grant_reg, status_reg};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_SHRD) rd_addr = AW'(idx_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR; cnt_reg <= CW'(1); blocks_reg <= '0;
            clr_reg <= '0; tvalid_reg <= 1'b0; mode_reg <= 2'd0;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next; cnt_reg <= cnt_next; blocks_reg <= blocks_next;
            clr_reg <= clr_next; tvalid_reg <= tvalid_next; mode_reg <= mode_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next; req_reg <= req_next; addr_reg <= addr_next;
        need_reg <= need_next; hdr_reg <= hdr_next; ps_reg <= ps_next;
        pl_reg <= pl_next; sum_reg <= sum_next; lo_reg <= lo_next;
        hi_reg <= hi_next; blen_reg <= blen_next; status_reg <= status_next;
        grant_reg <= grant_next; tdata_reg <= tdata_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_FREE_ENTRIES)) else $error("free table overflow");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> state_reg == S_IDLE) else $error("ready while busy");
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tvalid_reg) |-> $past(state_reg) == S_OUT) else $error("stray result");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tvalid_reg && !m_axis_tready |=> tvalid_reg && $stable(tdata_reg))
        else $error("result changed while waiting");
endmodule
